// ----- src/sbe_pkg.sv -----
// ----------------------------------------------------------------------------
// sbe_pkg
// Shared types, opcode and error codes, and a decode helper for the
// stack bytecode executor.
// ----------------------------------------------------------------------------
package sbe_pkg;

  localparam logic [3:0] OP_ICONST = 4'd0;
  localparam logic [3:0] OP_IADD   = 4'd1;
  localparam logic [3:0] OP_BEQ    = 4'd2;
  localparam logic [3:0] OP_CALL   = 4'd3;
  localparam logic [3:0] OP_CALLR  = 4'd4;
  localparam logic [3:0] OP_RET    = 4'd5;
  localparam logic [3:0] OP_LOCAL  = 4'd6;
  localparam logic [3:0] OP_PRINT  = 4'd7;
  localparam logic [3:0] OP_NOP    = 4'd8;
  localparam logic [3:0] OP_R2S    = 4'd9;
  localparam logic [3:0] OP_S2R    = 4'd10;

  localparam logic [1:0] ERR_OK    = 2'd0;
  localparam logic [1:0] ERR_OVER  = 2'd1;
  localparam logic [1:0] ERR_UNDER = 2'd2;
  localparam logic [1:0] ERR_REG   = 2'd3;

  typedef struct packed {
    logic        [3:0]  op;
    logic signed [31:0] arg_a;
    logic        [7:0]  arg_b;
  } in_item_t;

  typedef struct packed {
    logic        [11:0] next_addr;
    logic               print_valid;
    logic signed [31:0] print_value;
    logic        [1:0]  error;
  } out_item_t;

  // Classified instruction handed from front to back.
  typedef struct packed {
    logic [3:0]  op;
    logic [31:0] arg_a;
    logic [7:0]  arg_b;
    logic [1:0]  len;
    logic        reg_bad;
    logic        reg_sel;
  } dec_item_t;

  function automatic logic [1:0] op_len(input logic [3:0] op);
    logic [1:0] len;
    unique case (op)
      OP_ICONST, OP_BEQ, OP_LOCAL, OP_R2S, OP_S2R: len = 2'd2;
      OP_CALL, OP_CALLR:                           len = 2'd3;
      default:                                     len = 2'd1;
    endcase
    return len;
  endfunction

endpackage

// ----- src/sbe_ram.sv -----
// ----------------------------------------------------------------------------
// sbe_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module sbe_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en && we) begin
      mem[addr] <= wdata;
    end
    if (en && !we) begin
      rdata <= mem[addr];
    end
  end

endmodule

// ----- src/sbe_fifo.sv -----
// ----------------------------------------------------------------------------
// sbe_fifo
// Small register queue with push/full and pop/empty sides.
// ----------------------------------------------------------------------------
module sbe_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  output logic             full,
  input  logic [WIDTH-1:0] din,
  input  logic             pop,
  output logic             empty,
  output logic [WIDTH-1:0] dout
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot[wr_ptr] <= din;
    end
  end

endmodule

// ----- src/sbe_front.sv -----
// ----------------------------------------------------------------------------
// sbe_front
// Accept instructions, classify them (length, register check) and queue
// them for the execute side.
// ----------------------------------------------------------------------------
module sbe_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  sbe_pkg::in_item_t  in_item,
  input  logic               take,
  output logic               empty,
  output sbe_pkg::dec_item_t head
);

  sbe_pkg::dec_item_t dec;

  always_comb begin
    dec.op      = in_item.op;
    dec.arg_a   = in_item.arg_a;
    dec.arg_b   = in_item.arg_b;
    dec.len     = sbe_pkg::op_len(in_item.op);
    dec.reg_bad = |in_item.arg_a[31:1];
    dec.reg_sel = in_item.arg_a[0];
  end

  sbe_fifo #(
    .WIDTH($bits(sbe_pkg::dec_item_t)),
    .DEPTH(2)
  ) u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .full (full),
    .din  (dec),
    .pop  (take),
    .empty(empty),
    .dout (head)
  );

endmodule

// ----- src/sbe_back.sv -----
// ----------------------------------------------------------------------------
// sbe_back
// Execute classified instructions against the word stack RAM and the
// architectural registers; one RAM access per cycle.
// ----------------------------------------------------------------------------
module sbe_back #(
  parameter int STACK_DEPTH = 256,
  parameter int PROG_DEPTH  = 4096
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_empty,
  input  sbe_pkg::dec_item_t  head,
  output logic                take,
  input  logic                res_full,
  output logic                res_push,
  output sbe_pkg::out_item_t  res
);

  localparam int SW = $clog2(STACK_DEPTH);
  localparam int CW = SW + 1;
  localparam int FW = $clog2(PROG_DEPTH);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_R2   = 6'b000010,
    S_R3   = 6'b000100,
    S_R4   = 6'b001000,
    S_W2   = 6'b010000,
    S_W3   = 6'b100000
  } state_t;

  state_t             state, state_next;
  logic [CW-1:0]      cnt, cnt_next;
  logic [SW-1:0]      frame, frame_next;
  logic [FW-1:0]      fetch, fetch_next;
  logic [31:0]        scr0, scr0_next, scr1, scr1_next;
  sbe_pkg::dec_item_t cur, cur_next, ins;
  logic [31:0]        r0, r0_next, r1, r1_next;

  logic               ram_en, ram_we;
  logic [SW-1:0]      ram_addr;
  logic [31:0]        ram_wdata, ram_rdata;

  logic               fin;
  logic [1:0]         err;
  logic [FW-1:0]      nxt, seq, a_fw;
  logic [SW-1:0]      top0, top1, top2, push0, push1, push2;
  logic [CW-1:0]      cnt_m3;
  logic [31:0]        na32, avail;
  logic               stk_full, call_over;

  sbe_ram #(.WIDTH(32), .DEPTH(STACK_DEPTH)) u_stack (
    .clk  (clk),
    .en   (ram_en),
    .we   (ram_we),
    .addr (ram_addr),
    .wdata(ram_wdata),
    .rdata(ram_rdata)
  );

  always_comb begin
    ins       = (state == S_IDLE) ? head : cur;
    seq       = fetch + FW'(ins.len);
    a_fw      = ins.arg_a[FW-1:0];
    push0     = cnt[SW-1:0];
    push1     = cnt[SW-1:0] + SW'(1);
    push2     = cnt[SW-1:0] + SW'(2);
    top0      = cnt[SW-1:0] - SW'(1);
    top1      = cnt[SW-1:0] - SW'(2);
    top2      = cnt[SW-1:0] - SW'(3);
    cnt_m3    = cnt - CW'(3);
    avail     = 32'(cnt_m3);
    stk_full  = (cnt == CW'(STACK_DEPTH));
    call_over = (cnt > CW'(STACK_DEPTH - 3));
  end

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    frame_next = frame;
    scr0_next  = scr0;
    scr1_next  = scr1;
    cur_next   = cur;
    r0_next    = r0;
    r1_next    = r1;
    ram_en     = 1'b0;
    ram_we     = 1'b0;
    ram_addr   = top0;
    ram_wdata  = ins.arg_a;
    fin        = 1'b0;
    err        = sbe_pkg::ERR_OK;
    nxt        = seq;
    take       = 1'b0;
    res.print_valid = 1'b0;
    res.print_value = '0;

    unique case (state)
      S_IDLE: begin
        if (!q_empty && !res_full) begin
          take     = 1'b1;
          cur_next = head;
          unique case (ins.op)
            sbe_pkg::OP_ICONST: begin
              fin = 1'b1;
              if (stk_full) begin
                err = sbe_pkg::ERR_OVER;
              end else begin
                ram_en    = 1'b1;
                ram_we    = 1'b1;
                ram_addr  = push0;
                cnt_next  = cnt + CW'(1);
              end
            end
            sbe_pkg::OP_IADD, sbe_pkg::OP_BEQ: begin
              if (cnt < CW'(2)) begin
                fin = 1'b1;
                err = sbe_pkg::ERR_UNDER;
              end else begin
                ram_en     = 1'b1;
                state_next = S_R2;
              end
            end
            sbe_pkg::OP_CALL, sbe_pkg::OP_CALLR: begin
              if (call_over) begin
                fin = 1'b1;
                err = sbe_pkg::ERR_OVER;
              end else begin
                ram_en     = 1'b1;
                ram_we     = 1'b1;
                ram_addr   = push0;
                ram_wdata  = 32'(ins.arg_b);
                state_next = S_W2;
              end
            end
            sbe_pkg::OP_RET: begin
              if (cnt < CW'(3)) begin
                fin = 1'b1;
                err = sbe_pkg::ERR_UNDER;
              end else begin
                ram_en     = 1'b1;
                state_next = S_R2;
              end
            end
            sbe_pkg::OP_LOCAL: begin
              if (stk_full) begin
                fin = 1'b1;
                err = sbe_pkg::ERR_OVER;
              end else begin
                ram_en     = 1'b1;
                ram_addr   = frame - SW'(2);
                state_next = S_R2;
              end
            end
            sbe_pkg::OP_PRINT: begin
              if (cnt == '0) begin
                fin = 1'b1;
                err = sbe_pkg::ERR_UNDER;
              end else begin
                ram_en     = 1'b1;
                state_next = S_R2;
              end
            end
            sbe_pkg::OP_R2S: begin
              fin = 1'b1;
              if (ins.reg_bad) begin
                err = sbe_pkg::ERR_REG;
              end else if (stk_full) begin
                err = sbe_pkg::ERR_OVER;
              end else begin
                ram_en    = 1'b1;
                ram_we    = 1'b1;
                ram_addr  = push0;
                ram_wdata = ins.reg_sel ? scr1 : scr0;
                cnt_next  = cnt + CW'(1);
              end
            end
            sbe_pkg::OP_S2R: begin
              if (ins.reg_bad) begin
                fin = 1'b1;
                err = sbe_pkg::ERR_REG;
              end else if (cnt == '0) begin
                fin = 1'b1;
                err = sbe_pkg::ERR_UNDER;
              end else begin
                ram_en     = 1'b1;
                state_next = S_R2;
              end
            end
            default: begin
              fin = 1'b1;
            end
          endcase
        end
      end

      S_R2: begin
        r0_next = ram_rdata;
        unique case (ins.op)
          sbe_pkg::OP_IADD, sbe_pkg::OP_BEQ, sbe_pkg::OP_RET: begin
            ram_en     = 1'b1;
            ram_addr   = top1;
            state_next = S_R3;
          end
          sbe_pkg::OP_LOCAL: begin
            ram_en     = 1'b1;
            ram_addr   = frame - SW'(2) - ram_rdata[SW-1:0] + ins.arg_a[SW-1:0];
            state_next = S_R3;
          end
          sbe_pkg::OP_PRINT: begin
            fin             = 1'b1;
            res.print_valid = 1'b1;
            res.print_value = ram_rdata;
            cnt_next        = cnt - CW'(1);
            state_next      = S_IDLE;
          end
          default: begin
            // register load from the top of stack
            fin        = 1'b1;
            cnt_next   = cnt - CW'(1);
            state_next = S_IDLE;
            if (ins.reg_sel) begin
              scr1_next = ram_rdata;
            end else begin
              scr0_next = ram_rdata;
            end
          end
        endcase
      end

      S_R3: begin
        unique case (ins.op)
          sbe_pkg::OP_IADD: begin
            fin        = 1'b1;
            ram_en     = 1'b1;
            ram_we     = 1'b1;
            ram_addr   = top1;
            ram_wdata  = r0 + ram_rdata;
            cnt_next   = cnt - CW'(1);
            state_next = S_IDLE;
          end
          sbe_pkg::OP_BEQ: begin
            fin        = 1'b1;
            cnt_next   = cnt - CW'(2);
            nxt        = (r0 == ram_rdata) ? a_fw : seq;
            state_next = S_IDLE;
          end
          sbe_pkg::OP_RET: begin
            r1_next    = ram_rdata;
            ram_en     = 1'b1;
            ram_addr   = top2;
            state_next = S_R4;
          end
          default: begin
            // local: push the fetched element
            fin        = 1'b1;
            ram_en     = 1'b1;
            ram_we     = 1'b1;
            ram_addr   = push0;
            ram_wdata  = ram_rdata;
            cnt_next   = cnt + CW'(1);
            state_next = S_IDLE;
          end
        endcase
      end

      S_R4: begin
        fin        = 1'b1;
        state_next = S_IDLE;
        if (ram_rdata > avail) begin
          err = sbe_pkg::ERR_UNDER;
        end else begin
          cnt_next   = cnt_m3 - ram_rdata[CW-1:0];
          frame_next = r1[SW-1:0];
          nxt        = r0[FW-1:0];
        end
      end

      S_W2: begin
        ram_en     = 1'b1;
        ram_we     = 1'b1;
        ram_addr   = push1;
        ram_wdata  = 32'(frame);
        state_next = S_W3;
      end

      S_W3: begin
        fin        = 1'b1;
        ram_en     = 1'b1;
        ram_we     = 1'b1;
        ram_addr   = push2;
        ram_wdata  = 32'(seq);
        frame_next = push2;
        cnt_next   = cnt + CW'(3);
        nxt        = (ins.op == sbe_pkg::OP_CALL) ? a_fw : seq + a_fw;
        state_next = S_IDLE;
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase

    // an error leaves all architectural state as it was
    if (fin && err != sbe_pkg::ERR_OK) begin
      cnt_next   = cnt;
      frame_next = frame;
      scr0_next  = scr0;
      scr1_next  = scr1;
      ram_en     = 1'b0;
    end
    fetch_next = (fin && err == sbe_pkg::ERR_OK) ? nxt : fetch;
    na32       = 32'((err == sbe_pkg::ERR_OK) ? nxt : fetch);
    res.next_addr = na32[11:0];
    res.error     = err;
    res_push      = fin;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
      frame <= '0;
      fetch <= '0;
      scr0  <= '0;
      scr1  <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      frame <= frame_next;
      fetch <= fetch_next;
      scr0  <= scr0_next;
      scr1  <= scr1_next;
    end
  end

  always_ff @(posedge clk) begin
    cur <= cur_next;
    r0  <= r0_next;
    r1  <= r1_next;
  end

endmodule

// ----- src/stack_bytecode_executor_unit.sv -----
// Sequencing: inputs wait in the front queue; the execute side finishes push-only
// ops in S_IDLE, print and register load in S_R2, add, branch and local in S_R3,
// call in S_W3 and ret in S_R4, then pushes the result into the output queue. A new
// instruction starts only in S_IDLE, after the last ends; one RAM access per cycle.
// Reset: synchronous, clears queues, stack/frame pointers, fetch address and the
// scratch registers; stack RAM contents stay undefined (no clearing pass).
// ----------------------------------------------------------------------------
// stack_bytecode_executor_unit
// Stack-machine instruction executor with a decoupled front queue and an
// execute sequencer; results leave through a small output queue.
// STACK_DEPTH and PROG_DEPTH must be powers of two.
// ----------------------------------------------------------------------------
module stack_bytecode_executor_unit #(
  parameter int STACK_DEPTH = 256,
  parameter int PROG_DEPTH  = 4096
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  sbe_pkg::in_item_t  in_item,
  output logic               empty,
  input  logic               pop,
  output sbe_pkg::out_item_t out_item
);

  // front to back: classified instruction queue
  sbe_pkg::dec_item_t head;
  logic               q_empty;
  logic               take;

  // back to output queue
  sbe_pkg::out_item_t res;
  logic               res_push;
  logic               res_full;

  // Accept and classify; the queue lets input transfers continue while the
  // back end is busy with a multi-cycle instruction.
  sbe_front u_front (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .full   (full),
    .in_item(in_item),
    .take   (take),
    .empty  (q_empty),
    .head   (head)
  );

  // Execute; start an instruction only when the output queue has a slot,
  // so a finished result never waits on the sequencer.
  sbe_back #(
    .STACK_DEPTH(STACK_DEPTH),
    .PROG_DEPTH (PROG_DEPTH)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_empty),
    .head    (head),
    .take    (take),
    .res_full(res_full),
    .res_push(res_push),
    .res     (res)
  );

  // Hold results until the consumer transfers them.
  sbe_fifo #(
    .WIDTH($bits(sbe_pkg::out_item_t)),
    .DEPTH(2)
  ) u_out_queue (
    .clk  (clk),
    .rst  (rst),
    .push (res_push),
    .full (res_full),
    .din  (res),
    .pop  (pop),
    .empty(empty),
    .dout (out_item)
  );

  // A result is produced only into a free output slot.
  a_no_res_overflow: assert property (@(posedge clk) disable iff (rst)
    res_push |-> !res_full)
    else $error("result produced into a full output queue");

  // A printed value never comes with an error.
  a_print_ok: assert property (@(posedge clk) disable iff (rst)
    (!empty && out_item.print_valid) |-> (out_item.error == sbe_pkg::ERR_OK))
    else $error("print result carries an error code");

  // Instructions leave the front queue only when it holds one.
  a_take_valid: assert property (@(posedge clk) disable iff (rst)
    take |-> !q_empty)
    else $error("back end took from an empty instruction queue");

  // After reset the output queue is empty and the front queue is not full.
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> (empty && !full))
    else $error("queues not empty after reset");

endmodule

// ----- bench/stack_bytecode_executor_unit_tb.sv -----
// ----------------------------------------------------------------------------
// stack_bytecode_executor_unit_tb
// Self-checking bench for the stack bytecode executor. Directed instructions
// cover operand extremes, every opcode and the error paths. Random call
// frames, stack fills and noise follow, under three sender/receiver idling
// mixes. A scoreboard predicts every result in order and compares it field
// by field.
// ----------------------------------------------------------------------------
module stack_bytecode_executor_unit_tb;

  localparam int STK   = 256;
  localparam int PROG  = 4096;
  localparam int NRAND = 1700;

  // Executor shadow state plus the queue of results still owed.
  class exec_scoreboard;
    logic [31:0] stk [STK];
    bit          stk_written [STK];
    int unsigned top, fb, fa, r0, r1;
    sbe_pkg::out_item_t owed [$];
    int          n_fail, n_items, n_results, n_prints;
    int          n_err [4];

    function void clear();
      foreach (stk_written[i]) stk_written[i] = 0;
      top = 32'hFFFF_FFFF;
      fb = 0; fa = 0; r0 = 0; r1 = 0;
    endfunction

    function int unsigned held();
      return top + 1;
    endfunction

    function void push_word(logic [31:0] v);
      top = top + 1;
      stk[top % STK] = v;
      stk_written[top % STK] = 1;
    endfunction

    function logic [31:0] pop_word();
      logic [31:0] v;
      v = stk[top % STK];
      top = top - 1;
      return v;
    endfunction

    // Pick a local index whose count word and element were both written (any index when the stack is full).
    function bit pick_local(output logic [31:0] a);
      int unsigned c, addr;
      a = '0;
      if (held() >= STK) begin
        a = $urandom;
        return 1;
      end
      if (!stk_written[(fb + STK - 2) % STK]) return 0;
      c = stk[(fb + STK - 2) % STK];
      for (int t = 0; t < 8; t++) begin
        if (t < 5 && c > 0 && c <= STK) a = $urandom_range(c - 1);
        else a = (t == 7) ? $urandom : $urandom_range(8);
        addr = (fb - 2 - c + a) % STK;
        if (stk_written[addr]) return 1;
      end
      return 0;
    endfunction

    // Note an accepted instruction: advance the shadow state and queue the result.
    function void note(sbe_pkg::in_item_t it);
      int unsigned n, nxt, a, b, x, y, r, f, c, addr;
      logic [1:0] err;
      sbe_pkg::out_item_t e;
      n = held();
      a = it.arg_a;
      b = 32'(it.arg_b);
      err = sbe_pkg::ERR_OK;
      e = '0;
      case (it.op)
        sbe_pkg::OP_ICONST, sbe_pkg::OP_BEQ, sbe_pkg::OP_LOCAL, sbe_pkg::OP_R2S,
        sbe_pkg::OP_S2R: nxt = (fa + 2) % PROG;
        sbe_pkg::OP_CALL, sbe_pkg::OP_CALLR: nxt = (fa + 3) % PROG;
        default: nxt = (fa + 1) % PROG;
      endcase
      case (it.op)
        sbe_pkg::OP_ICONST: begin
          if (n >= STK) err = sbe_pkg::ERR_OVER; else push_word(a);
        end
        sbe_pkg::OP_IADD: begin
          if (n < 2) err = sbe_pkg::ERR_UNDER;
          else begin
            x = pop_word(); y = pop_word(); push_word(x + y);
          end
        end
        sbe_pkg::OP_BEQ: begin
          if (n < 2) err = sbe_pkg::ERR_UNDER;
          else begin
            x = pop_word(); y = pop_word();
            if (x == y) nxt = a % PROG;
          end
        end
        sbe_pkg::OP_CALL, sbe_pkg::OP_CALLR: begin
          if (n > STK - 3) err = sbe_pkg::ERR_OVER;
          else begin
            push_word(b); push_word(fb); push_word(nxt);
            fb = top % STK;
            nxt = (it.op == sbe_pkg::OP_CALL) ? a % PROG : (nxt + a) % PROG;
          end
        end
        sbe_pkg::OP_RET: begin
          if (n < 3) err = sbe_pkg::ERR_UNDER;
          else begin
            r = stk[top % STK];
            f = stk[(top - 1) % STK];
            c = stk[(top - 2) % STK];
            if (c > n - 3) err = sbe_pkg::ERR_UNDER;
            else begin
              top = top - 3 - c;
              fb = f % STK;
              nxt = r % PROG;
            end
          end
        end
        sbe_pkg::OP_LOCAL: begin
          if (n >= STK) err = sbe_pkg::ERR_OVER;
          else begin
            c = stk[(fb + STK - 2) % STK];
            addr = (fb - 2 - c + a) % STK;
            push_word(stk[addr]);
          end
        end
        sbe_pkg::OP_PRINT: begin
          if (n < 1) err = sbe_pkg::ERR_UNDER;
          else begin
            e.print_value = pop_word();
            e.print_valid = 1'b1;
          end
        end
        sbe_pkg::OP_R2S: begin
          if (a > 1) err = sbe_pkg::ERR_REG;
          else if (n >= STK) err = sbe_pkg::ERR_OVER;
          else push_word(a == 0 ? r0 : r1);
        end
        sbe_pkg::OP_S2R: begin
          if (a > 1) err = sbe_pkg::ERR_REG;
          else if (n < 1) err = sbe_pkg::ERR_UNDER;
          else if (a == 0) r0 = pop_word();
          else r1 = pop_word();
        end
        default: ;
      endcase
      if (err != sbe_pkg::ERR_OK) begin
        nxt = fa;
        e.print_valid = 1'b0;
        e.print_value = '0;
      end else begin
        fa = nxt;
      end
      e.next_addr = nxt[11:0];
      e.error = err;
      n_err[err]++;
      n_items++;
      owed.push_back(e);
    endfunction

    // Check one transferred result against the oldest owed one.
    function void check(sbe_pkg::out_item_t got);
      sbe_pkg::out_item_t e;
      if (owed.size() == 0) begin
        $display("%0t: result with none owed: %p", $time, got);
        n_fail++;
        return;
      end
      e = owed.pop_front();
      n_results++;
      if (got.print_valid) n_prints++;
      if (got.next_addr !== e.next_addr) begin
        $display("%0t: next_addr exp %h got %h", $time, e.next_addr, got.next_addr);
        n_fail++;
      end
      if (got.print_valid !== e.print_valid) begin
        $display("%0t: print_valid exp %b got %b", $time, e.print_valid, got.print_valid);
        n_fail++;
      end
      if (got.print_value !== e.print_value) begin
        $display("%0t: print_value exp %h got %h", $time, e.print_value, got.print_value);
        n_fail++;
      end
      if (got.error !== e.error) begin
        $display("%0t: error exp %0d got %0d", $time, e.error, got.error);
        n_fail++;
      end
    endfunction
  endclass

  logic               clk, rst, push, pop;
  logic               full, empty;
  sbe_pkg::in_item_t  in_item;
  sbe_pkg::out_item_t out_item;

  int tx_idle, rx_idle;
  exec_scoreboard sb;

  stack_bytecode_executor_unit u_top (
    .clk(clk), .rst(rst), .push(push), .full(full), .in_item(in_item),
    .empty(empty), .pop(pop), .out_item(out_item)
  );

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  // Send one instruction; enter and leave at a falling edge.
  task automatic send(logic [3:0] op, logic [31:0] a, logic [7:0] b);
    sbe_pkg::in_item_t it;
    it.op = op;
    it.arg_a = a;
    it.arg_b = b;
    while ($urandom_range(99) < tx_idle) begin
      push <= 0;
      @(negedge clk);
    end
    push <= 1;
    in_item <= it;
    do @(posedge clk); while (full);
    sb.note(it);
    @(negedge clk);
  endtask

  task automatic send_local();
    logic [31:0] a;
    if (sb.pick_local(a)) send(sbe_pkg::OP_LOCAL, a, 8'($urandom));
    else send(sbe_pkg::OP_NOP, a, 8'($urandom));
  endtask

  // One call frame: args, call, a body, drain the body, and usually a return.
  task automatic call_frame();
    int k, depth;
    k = $urandom_range(4);
    repeat (k) send(sbe_pkg::OP_ICONST, $urandom, 8'($urandom));
    send($urandom_range(1) ? sbe_pkg::OP_CALL : sbe_pkg::OP_CALLR, $urandom,
         ($urandom_range(9) == 0) ? 8'($urandom) : 8'(k));
    depth = sb.held();
    repeat ($urandom_range(1, 6)) begin
      case ($urandom_range(5))
        0: send(sbe_pkg::OP_ICONST, $urandom, 8'($urandom));
        1: send_local();
        2: send(sbe_pkg::OP_IADD, $urandom, 8'($urandom));
        3: send(sbe_pkg::OP_R2S, $urandom_range(1), 8'($urandom));
        4: send(sbe_pkg::OP_S2R, $urandom_range(1), 8'($urandom));
        default: send(sbe_pkg::OP_BEQ, $urandom, 8'($urandom));
      endcase
    end
    while (sb.held() > depth && sb.held() <= STK)
      send(sbe_pkg::OP_PRINT, $urandom, 8'($urandom));
    if ($urandom_range(4) != 0) send(sbe_pkg::OP_RET, $urandom, 8'($urandom));
  endtask

  // Random noise instruction over the whole operand space.
  task automatic noise();
    logic [3:0] op;
    logic [31:0] a;
    op = 4'($urandom_range(15));
    a = $urandom_range(3) == 0 ? $urandom_range(1) : $urandom;
    if (op == sbe_pkg::OP_LOCAL) send_local();
    else send(op, a, 8'($urandom));
  endtask

  // Result side: sample at the rising edge, reroll pop at the falling edge.
  initial begin
    pop = 0;
    forever begin
      @(posedge clk);
      if (!rst && pop && !empty) sb.check(out_item);
      @(negedge clk);
      pop <= ($urandom_range(99) >= rx_idle);
    end
  end

  initial begin
    #(8 * 2000000);
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    int wait_cyc;
    sb = new();
    sb.clear();
    rst = 1; push = 0; in_item = '0;
    tx_idle = 0; rx_idle = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    // Directed: empty-stack errors, bad registers, extremes, every opcode.
    send(sbe_pkg::OP_IADD, 0, 0);
    send(sbe_pkg::OP_PRINT, 0, 0);
    send(sbe_pkg::OP_RET, 0, 0);
    send(sbe_pkg::OP_S2R, 0, 0);
    send(sbe_pkg::OP_R2S, 2, 0);
    send(sbe_pkg::OP_S2R, 32'hFFFF_FFFF, 0);
    send(sbe_pkg::OP_R2S, 0, 0);
    send(sbe_pkg::OP_R2S, 1, 0);
    send(sbe_pkg::OP_ICONST, 32'h7FFF_FFFF, 8'hFF);
    send(sbe_pkg::OP_ICONST, 32'h0000_0001, 0);
    send(sbe_pkg::OP_IADD, 0, 0);          // wraps to the most negative value
    send(sbe_pkg::OP_ICONST, 32'h8000_0000, 0);
    send(sbe_pkg::OP_BEQ, 32'hFFFF_FFFF, 0); // equal: jump taken
    send(sbe_pkg::OP_ICONST, 5, 0);
    send(sbe_pkg::OP_ICONST, 6, 0);
    send(sbe_pkg::OP_BEQ, 100, 0);           // unequal: fall through
    send(sbe_pkg::OP_ICONST, 77, 0);
    send(sbe_pkg::OP_CALL, 32'hFFFF_F000, 1);
    send_local();
    send(sbe_pkg::OP_S2R, 1, 0);
    send(sbe_pkg::OP_RET, 0, 0);
    send(sbe_pkg::OP_CALLR, 32'h8000_0000, 8'hFF);
    send(sbe_pkg::OP_RET, 0, 0);             // saved count exceeds stack: underflow
    send(sbe_pkg::OP_NOP, 0, 0);
    send(4'd15, 32'hFFFF_FFFF, 8'hFF);

    // Random: three idling mixes, one pause for a full drain.
    for (int ph = 0; ph < 3; ph++) begin
      tx_idle = (ph == 0) ? 21 : (ph == 1) ? 57 : 0;
      rx_idle = (ph == 0) ? 57 : (ph == 1) ? 21 : 0;
      while (sb.n_items < 25 + (ph + 1) * NRAND / 3) begin
        case ($urandom_range(9))
          0, 1, 2, 3, 4: call_frame();
          5: begin
            // fill to overflow, then drain part way
            while (sb.held() < STK) send(sbe_pkg::OP_ICONST, $urandom, 8'($urandom));
            send($urandom_range(1) ? sbe_pkg::OP_CALL : sbe_pkg::OP_ICONST, $urandom,
                 8'($urandom));
            send_local();
            repeat ($urandom_range(20, 200)) send(sbe_pkg::OP_PRINT, 0, 0);
          end
          default: noise();
        endcase
        if (sb.held() > 200 && sb.held() <= STK) repeat (60) send(sbe_pkg::OP_PRINT, 0, 0);
      end
      if (ph == 0) begin
        push <= 0;
        while (sb.owed.size() != 0) @(negedge clk);
      end
    end
    push <= 0;

    wait_cyc = 0;
    while (sb.owed.size() != 0 && wait_cyc < 100000) begin
      @(posedge clk);
      wait_cyc++;
    end
    repeat (10) @(posedge clk);
    if (sb.owed.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, sb.owed.size());
      sb.n_fail++;
    end
    $display("Ran %0d instructions, checked %0d results, %0d prints", sb.n_items,
             sb.n_results, sb.n_prints);
    $display("Errors seen: ok %0d overflow %0d underflow %0d bad reg %0d",
             sb.n_err[0], sb.n_err[1], sb.n_err[2], sb.n_err[3]);
    if (sb.n_fail == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
